### rtl/core/ihq_pkg.sv
// ----------------------------------------------------------------------------
// ihq_pkg
// Shared types and constants of the indexed min-heap queue: sizes, opcodes,
// status codes, microcode control word and datapath condition flags.
// ----------------------------------------------------------------------------
package ihq_pkg;

    localparam int HEAP_CAPACITY = 256;
    localparam int KEY_BITS      = 32;

    localparam int OPCODE_W      = 2;
    localparam int VERTEX_W      = 8;
    localparam int KEY_IN_W      = 32;
    localparam int STATUS_W      = 3;
    localparam int COUNT_OUT_W   = 9;

    localparam int NUM_VERTICES  = 2 ** VERTEX_W;
    // heap slots 1..HEAP_CAPACITY; count 0..HEAP_CAPACITY
    localparam int SLOT_W        = $clog2(HEAP_CAPACITY + 1);
    localparam int CNT_W         = SLOT_W;

    localparam int UPC_W         = 5;

    typedef logic [UPC_W-1:0] t_upc;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_CHANGE = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_FULL    = 3'd2,
        ST_ABSENT  = 3'd3,
        ST_PRESENT = 3'd4
    } t_status;

    // jump conditions
    typedef enum logic [3:0] {
        JC_NEVER,
        JC_ALWAYS,
        JC_NO_ACCEPT,
        JC_OPCODE,      // multiway: target + opcode
        JC_PRESENT,
        JC_ABSENT,
        JC_FULL,
        JC_EMPTY,
        JC_ROOT,
        JC_NOT_LESS,
        JC_LAST,
        JC_NO_CHILD,
        JC_CHILD_GE,
        JC_KEY_EQ,
        JC_OUT_BUSY
    } t_jc;

    // heap read port addressing
    typedef enum logic [2:0] {
        RD_NONE,
        RD_ROOT_LAST,
        RD_PARENT,
        RD_CHILDREN,
        RD_SLOT
    } t_rd;

    // heap / map write selection (heap writes always go to the hole slot)
    typedef enum logic [2:0] {
        WR_NONE,
        WR_UNMAP,
        WR_PARENT,
        WR_CHILD,
        WR_ENTRY
    } t_wr;

    // datapath register operations
    typedef enum logic [3:0] {
        DP_NONE,
        DP_LATCH,
        DP_INS_SETUP,
        DP_CHG_SETUP,
        DP_POP_SETUP,
        DP_UP,
        DP_DOWN,
        DP_SET_ST,
        DP_OUT
    } t_dp;

    typedef struct packed {
        logic    ready;
        t_jc     jc;
        t_upc    target;
        t_rd     rd;
        t_wr     wr;
        t_dp     dp;
        t_status st;
    } t_ctl;

    typedef struct packed {
        t_opcode op;
        logic    in_valid;
        logic    present;
        logic    full;
        logic    empty;
        logic    root;
        logic    not_less;
        logic    last;
        logic    no_child;
        logic    child_ge;
        logic    key_eq;
        logic    out_busy;
    } t_flags;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [VERTEX_W-1:0] vtx;
    } t_entry;

endpackage

### rtl/core/ihq_seq.sv
// ----------------------------------------------------------------------------
// ihq_seq
// Microcode sequencer: step counter, control store and jump logic.
// ----------------------------------------------------------------------------
module ihq_seq import ihq_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_ctl   o_ctl
);

    localparam t_upc S_IDLE    = t_upc'(0);
    localparam t_upc S_FETCH   = t_upc'(1);
    localparam t_upc S_DISP    = t_upc'(2);
    localparam t_upc S_JT_INS  = t_upc'(3);   // jump table, one entry per opcode
    localparam t_upc S_JT_POP  = t_upc'(4);
    localparam t_upc S_JT_CHG  = t_upc'(5);
    localparam t_upc S_JT_NOP  = t_upc'(6);
    localparam t_upc S_INS0    = t_upc'(7);
    localparam t_upc S_INS1    = t_upc'(8);
    localparam t_upc S_INS2    = t_upc'(9);
    localparam t_upc S_CHG0    = t_upc'(10);
    localparam t_upc S_CHG1    = t_upc'(11);
    localparam t_upc S_CHG2    = t_upc'(12);
    localparam t_upc S_CHG3    = t_upc'(13);
    localparam t_upc S_CHG4    = t_upc'(14);
    localparam t_upc S_POP0    = t_upc'(15);
    localparam t_upc S_POP1    = t_upc'(16);
    localparam t_upc S_DN0     = t_upc'(17);
    localparam t_upc S_DN1     = t_upc'(18);
    localparam t_upc S_DN2     = t_upc'(19);
    localparam t_upc S_UP0     = t_upc'(20);
    localparam t_upc S_UP1     = t_upc'(21);
    localparam t_upc S_UP2     = t_upc'(22);
    localparam t_upc S_PLACE   = t_upc'(23);
    localparam t_upc S_E_PRES  = t_upc'(24);
    localparam t_upc S_E_FULL  = t_upc'(25);
    localparam t_upc S_E_ABS   = t_upc'(26);
    localparam t_upc S_E_EMPTY = t_upc'(27);
    localparam t_upc S_DONE    = t_upc'(28);
    localparam t_upc S_RET     = t_upc'(29);

    t_upc r_upc;
    t_upc n_upc;
    t_ctl ctl;
    logic take;

    // control store
    always_comb begin
        ctl = '{ready: 1'b0, jc: JC_NEVER, target: S_IDLE, rd: RD_NONE,
                wr: WR_NONE, dp: DP_NONE, st: ST_OK};
        case (r_upc)
            S_IDLE: begin
                ctl.ready  = 1'b1;
                ctl.dp     = DP_LATCH;
                ctl.jc     = JC_NO_ACCEPT;
                ctl.target = S_IDLE;
            end
            S_FETCH: begin
                ctl.rd = RD_ROOT_LAST;
            end
            S_DISP: begin
                ctl.jc     = JC_OPCODE;
                ctl.target = S_JT_INS;
            end
            S_JT_INS: begin
                ctl.jc     = JC_ALWAYS;
                ctl.target = S_INS0;
            end
            S_JT_POP: begin
                ctl.jc     = JC_ALWAYS;
                ctl.target = S_POP0;
            end
            S_JT_CHG: begin
                ctl.jc     = JC_ALWAYS;
                ctl.target = S_CHG0;
            end
            S_JT_NOP: begin
                ctl.jc     = JC_ALWAYS;
                ctl.target = S_DONE;
            end
            S_INS0: begin
                ctl.jc     = JC_PRESENT;
                ctl.target = S_E_PRES;
            end
            S_INS1: begin
                ctl.jc     = JC_FULL;
                ctl.target = S_E_FULL;
            end
            S_INS2: begin
                ctl.dp     = DP_INS_SETUP;
                ctl.jc     = JC_ALWAYS;
                ctl.target = S_UP0;
            end
            S_CHG0: begin
                ctl.jc     = JC_ABSENT;
                ctl.target = S_E_ABS;
            end
            S_CHG1: begin
                ctl.dp = DP_CHG_SETUP;
                ctl.rd = RD_SLOT;
            end
            S_CHG2: begin
                ctl.jc     = JC_KEY_EQ;
                ctl.target = S_DONE;
            end
            S_CHG3: begin
                ctl.jc     = JC_NOT_LESS;
                ctl.target = S_DN0;
            end
            S_CHG4: begin
                ctl.jc     = JC_ALWAYS;
                ctl.target = S_UP0;
            end
            S_POP0: begin
                ctl.jc     = JC_EMPTY;
                ctl.target = S_E_EMPTY;
            end
            S_POP1: begin
                // sole entry: nothing to sift; otherwise fall into sift-down
                ctl.wr     = WR_UNMAP;
                ctl.dp     = DP_POP_SETUP;
                ctl.jc     = JC_LAST;
                ctl.target = S_DONE;
            end
            S_DN0: begin
                ctl.rd     = RD_CHILDREN;
                ctl.jc     = JC_NO_CHILD;
                ctl.target = S_PLACE;
            end
            S_DN1: begin
                ctl.jc     = JC_CHILD_GE;
                ctl.target = S_PLACE;
            end
            S_DN2: begin
                ctl.wr     = WR_CHILD;
                ctl.dp     = DP_DOWN;
                ctl.jc     = JC_ALWAYS;
                ctl.target = S_DN0;
            end
            S_UP0: begin
                ctl.rd     = RD_PARENT;
                ctl.jc     = JC_ROOT;
                ctl.target = S_PLACE;
            end
            S_UP1: begin
                ctl.jc     = JC_NOT_LESS;
                ctl.target = S_PLACE;
            end
            S_UP2: begin
                ctl.wr     = WR_PARENT;
                ctl.dp     = DP_UP;
                ctl.jc     = JC_ALWAYS;
                ctl.target = S_UP0;
            end
            S_PLACE: begin
                ctl.wr     = WR_ENTRY;
                ctl.jc     = JC_ALWAYS;
                ctl.target = S_DONE;
            end
            S_E_PRES: begin
                ctl.dp     = DP_SET_ST;
                ctl.st     = ST_PRESENT;
                ctl.jc     = JC_ALWAYS;
                ctl.target = S_DONE;
            end
            S_E_FULL: begin
                ctl.dp     = DP_SET_ST;
                ctl.st     = ST_FULL;
                ctl.jc     = JC_ALWAYS;
                ctl.target = S_DONE;
            end
            S_E_ABS: begin
                ctl.dp     = DP_SET_ST;
                ctl.st     = ST_ABSENT;
                ctl.jc     = JC_ALWAYS;
                ctl.target = S_DONE;
            end
            S_E_EMPTY: begin
                ctl.dp     = DP_SET_ST;
                ctl.st     = ST_EMPTY;
                ctl.jc     = JC_ALWAYS;
                ctl.target = S_DONE;
            end
            S_DONE: begin
                // waits here while the output register is still occupied
                ctl.dp     = DP_OUT;
                ctl.jc     = JC_OUT_BUSY;
                ctl.target = S_DONE;
            end
            S_RET: begin
                ctl.jc     = JC_ALWAYS;
                ctl.target = S_IDLE;
            end
            default: begin
                ctl.jc     = JC_ALWAYS;
                ctl.target = S_IDLE;
            end
        endcase
    end

    always_comb begin
        case (ctl.jc)
            JC_NEVER:     take = 1'b0;
            JC_ALWAYS:    take = 1'b1;
            JC_NO_ACCEPT: take = !i_flags.in_valid;
            JC_OPCODE:    take = 1'b1;
            JC_PRESENT:   take = i_flags.present;
            JC_ABSENT:    take = !i_flags.present;
            JC_FULL:      take = i_flags.full;
            JC_EMPTY:     take = i_flags.empty;
            JC_ROOT:      take = i_flags.root;
            JC_NOT_LESS:  take = i_flags.not_less;
            JC_LAST:      take = i_flags.last;
            JC_NO_CHILD:  take = i_flags.no_child;
            JC_CHILD_GE:  take = i_flags.child_ge;
            JC_KEY_EQ:    take = i_flags.key_eq;
            JC_OUT_BUSY:  take = i_flags.out_busy;
            default:      take = 1'b0;
        endcase
    end

    always_comb begin
        if (!take) begin
            n_upc = r_upc + t_upc'(1);
        end else if (ctl.jc == JC_OPCODE) begin
            n_upc = ctl.target + t_upc'(i_flags.op);
        end else begin
            n_upc = ctl.target;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= S_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_ctl = ctl;

endmodule

### rtl/core/ihq_dp.sv
// ----------------------------------------------------------------------------
// ihq_dp
// Heap datapath: heap slot memory, vertex-to-slot map with valid bits,
// working registers, comparators and the output register.
// ----------------------------------------------------------------------------
module ihq_dp import ihq_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_ctl                   i_ctl,
    output t_flags                 o_flags,
    input  logic                   i_valid,
    input  logic [OPCODE_W-1:0]    i_opcode,
    input  logic [VERTEX_W-1:0]    i_vertex_id,
    input  logic [KEY_IN_W-1:0]    i_key,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [VERTEX_W-1:0]    o_out_vertex,
    output logic [KEY_IN_W-1:0]    o_out_key,
    output logic [STATUS_W-1:0]    o_status,
    output logic [COUNT_OUT_W-1:0] o_entry_count_now
);

    // heap storage, slot 0 unused
    t_entry               mem_heap [2**SLOT_W];
    logic [SLOT_W-1:0]    mem_map  [NUM_VERTICES];
    logic [NUM_VERTICES-1:0] r_map_vld;

    t_opcode              r_op;
    logic [VERTEX_W-1:0]  r_vtx;
    logic [KEY_BITS-1:0]  r_key;
    logic [CNT_W-1:0]     r_cnt;
    logic [SLOT_W-1:0]    r_cur;    // current hole slot
    t_entry               r_ent;    // entry being sifted
    t_entry               r_qa;
    t_entry               r_qb;
    logic [SLOT_W-1:0]    r_mq;     // map lookup of r_vtx, 0 when absent
    logic [VERTEX_W-1:0]  r_ov;
    logic [KEY_BITS-1:0]  r_ok;
    t_status              r_st;

    logic                   r_o_vld;
    logic                   n_o_vld;
    logic [VERTEX_W-1:0]    r_o_vtx;
    logic [KEY_IN_W-1:0]    r_o_key;
    t_status                r_o_st;
    logic [COUNT_OUT_W-1:0] r_o_cnt;

    logic              accept;
    logic              out_busy;
    logic              out_load;
    logic [SLOT_W:0]   lc;
    logic [SLOT_W:0]   rc;
    logic              use_r;
    t_entry            child;
    logic [SLOT_W-1:0] child_slot;
    logic [SLOT_W-1:0] addr_a;
    logic [SLOT_W-1:0] addr_b;
    logic              heap_we;
    t_entry            heap_wdata;
    logic              map_clr;

    assign accept   = i_valid && i_ctl.ready;
    assign out_busy = r_o_vld && !i_ready;
    assign out_load = (i_ctl.dp == DP_OUT) && !out_busy;

    // children of the hole; right child wins only on a strictly smaller key
    assign lc         = {r_cur, 1'b0};
    assign rc         = {r_cur, 1'b1};
    assign use_r      = (rc <= {1'b0, r_cnt}) && (r_qb.key < r_qa.key);
    assign child      = use_r ? r_qb : r_qa;
    assign child_slot = use_r ? rc[SLOT_W-1:0] : lc[SLOT_W-1:0];

    always_comb begin
        addr_a = '0;
        addr_b = '0;
        case (i_ctl.rd)
            RD_ROOT_LAST: begin
                addr_a = SLOT_W'(1);
                addr_b = r_cnt;
            end
            RD_PARENT:   addr_a = r_cur >> 1;
            RD_CHILDREN: begin
                addr_a = lc[SLOT_W-1:0];
                addr_b = rc[SLOT_W-1:0];
            end
            RD_SLOT:     addr_a = r_mq;
            default:     addr_a = '0;
        endcase
    end

    always_comb begin
        heap_we    = 1'b0;
        heap_wdata = r_ent;
        map_clr    = 1'b0;
        case (i_ctl.wr)
            WR_UNMAP:  map_clr = 1'b1;
            WR_PARENT: begin
                heap_we    = 1'b1;
                heap_wdata = r_qa;
            end
            WR_CHILD: begin
                heap_we    = 1'b1;
                heap_wdata = child;
            end
            WR_ENTRY: begin
                heap_we    = 1'b1;
                heap_wdata = r_ent;
            end
            default: heap_we = 1'b0;
        endcase
    end

    always_comb begin
        n_o_vld = r_o_vld;
        if (out_load) begin
            n_o_vld = 1'b1;
        end else if (r_o_vld && i_ready) begin
            n_o_vld = 1'b0;
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (heap_we) begin
            mem_heap[r_cur] <= heap_wdata;
            mem_map[heap_wdata.vtx] <= r_cur;
        end
        if (i_ctl.rd != RD_NONE) begin
            r_qa <= mem_heap[addr_a];
            r_qb <= mem_heap[addr_b];
        end
        r_mq <= r_map_vld[r_vtx] ? mem_map[r_vtx] : '0;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_o_vld   <= 1'b0;
            r_map_vld <= '0;
        end else begin
            r_o_vld <= n_o_vld;
            if (heap_we) begin
                r_map_vld[heap_wdata.vtx] <= 1'b1;
            end
            if (map_clr) begin
                r_map_vld[r_qa.vtx] <= 1'b0;
            end
            if (i_ctl.dp == DP_INS_SETUP) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_ctl.dp == DP_POP_SETUP) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_ctl.dp)
            DP_LATCH: begin
                if (accept) begin
                    r_op  <= t_opcode'(i_opcode);
                    r_vtx <= i_vertex_id;
                    r_key <= KEY_BITS'(i_key);
                    r_ov  <= '0;
                    r_ok  <= '0;
                    r_st  <= ST_OK;
                end
            end
            DP_INS_SETUP: begin
                r_cur <= r_cnt + CNT_W'(1);
                r_ent <= '{key: r_key, vtx: r_vtx};
            end
            DP_CHG_SETUP: begin
                r_cur <= r_mq;
                r_ent <= '{key: r_key, vtx: r_vtx};
            end
            DP_POP_SETUP: begin
                r_ov  <= r_qa.vtx;
                r_ok  <= r_qa.key;
                r_ent <= r_qb;
                r_cur <= SLOT_W'(1);
            end
            DP_UP:     r_cur <= r_cur >> 1;
            DP_DOWN:   r_cur <= child_slot;
            DP_SET_ST: r_st  <= i_ctl.st;
            DP_OUT: begin
                if (out_load) begin
                    r_o_vtx <= r_ov;
                    r_o_key <= KEY_IN_W'(r_ok);
                    r_o_st  <= r_st;
                    r_o_cnt <= COUNT_OUT_W'(r_cnt);
                end
            end
            default: r_cur <= r_cur;
        endcase
    end

    always_comb begin
        o_flags.op       = r_op;
        o_flags.in_valid = i_valid;
        o_flags.present  = (r_mq != '0) && (r_mq <= r_cnt);
        o_flags.full     = r_cnt >= CNT_W'(HEAP_CAPACITY);
        o_flags.empty    = r_cnt == '0;
        o_flags.root     = r_cur == SLOT_W'(1);
        o_flags.not_less = !(r_ent.key < r_qa.key);
        o_flags.last     = r_cnt == CNT_W'(1);
        o_flags.no_child = lc > {1'b0, r_cnt};
        o_flags.child_ge = r_ent.key <= child.key;
        o_flags.key_eq   = r_ent.key == r_qa.key;
        o_flags.out_busy = out_busy;
    end

    assign o_valid           = r_o_vld;
    assign o_out_vertex      = r_o_vtx;
    assign o_out_key         = r_o_key;
    assign o_status          = r_o_st;
    assign o_entry_count_now = r_o_cnt;

endmodule

### rtl/core/indexed_min_heap_queue_top.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_top
// Indexed binary min-heap priority queue with insert, pop-min and change-key,
// run by a microcoded sequencer over a heap/map datapath.
// ----------------------------------------------------------------------------
//  Channel   Handshake           Payload
//  -------   ------------------  ---------------------------------------------
//  request   i_valid / o_ready   i_opcode, i_vertex_id, i_key
//  result    o_valid / i_ready   o_out_vertex, o_out_key, o_status,
//                                o_entry_count_now
//
//  One transaction at a time. Errors, no-op, equal-key change and a pop of the
//  sole entry finish without a sift; a sift moves the entry one level per pass
//  of the level loop (heap read, compare, write through one memory), and a
//  full sift moves it up to 8 levels.
//  Reset clears the count and the map valid bits at once; no clearing pass.
//  A result stalled at the output holds the sequencer in its final step; the
//  next request is accepted once the result has moved to the output register.
// ----------------------------------------------------------------------------
module indexed_min_heap_queue_top import ihq_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [OPCODE_W-1:0]    i_opcode,
    input  logic [VERTEX_W-1:0]    i_vertex_id,
    input  logic [KEY_IN_W-1:0]    i_key,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [VERTEX_W-1:0]    o_out_vertex,
    output logic [KEY_IN_W-1:0]    o_out_key,
    output logic [STATUS_W-1:0]    o_status,
    output logic [COUNT_OUT_W-1:0] o_entry_count_now
);

    t_ctl   ctl;
    t_flags flags;

    ihq_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctl   (ctl)
    );

    ihq_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (ctl),
        .o_flags           (flags),
        .i_valid           (i_valid),
        .i_opcode          (i_opcode),
        .i_vertex_id       (i_vertex_id),
        .i_key             (i_key),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_out_vertex      (o_out_vertex),
        .o_out_key         (o_out_key),
        .o_status          (o_status),
        .o_entry_count_now (o_entry_count_now)
    );

    assign o_ready = ctl.ready;

endmodule

### rtl/core/ihq_chk.sv
// ----------------------------------------------------------------------------
// ihq_chk
// Port-level checks of the heap queue, bound to the top level.
// ----------------------------------------------------------------------------
module ihq_chk import ihq_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_valid,
    input logic                   o_ready,
    input logic                   o_valid,
    input logic                   i_ready,
    input logic [VERTEX_W-1:0]    o_out_vertex,
    input logic [KEY_IN_W-1:0]    o_out_key,
    input logic [STATUS_W-1:0]    o_status,
    input logic [COUNT_OUT_W-1:0] o_entry_count_now
);

    // one request transaction in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request accepted while previous one still running");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_vertex) &&
        $stable(o_out_key) && $stable(o_status) && $stable(o_entry_count_now))
        else $error("stalled result changed");

    // a result never appears in the cycle right after an accept
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !$past(i_valid && o_ready))
        else $error("result too early after accept");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_EMPTY) |-> o_entry_count_now == '0)
        else $error("empty status with nonzero count");

    a_fail_no_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> (o_out_vertex == '0) && (o_out_key == '0))
        else $error("failed transaction returned an entry");

endmodule

bind indexed_min_heap_queue_top ihq_chk u_ihq_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_ready           (o_ready),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_out_vertex      (o_out_vertex),
    .o_out_key         (o_out_key),
    .o_status          (o_status),
    .o_entry_count_now (o_entry_count_now)
);
